### rtl/tli_pkg.sv
// shared types and constants for the table linear interpolator
package tli_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgElasticMode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEntryCount  = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [2:0] RegionBelow  = 3'd0;
  localparam logic [2:0] RegionBefore = 3'd1;
  localparam logic [2:0] RegionExact  = 3'd2;
  localparam logic [2:0] RegionInterp = 3'd3;
  localparam logic [2:0] RegionBeyond = 3'd4;

  typedef struct packed {
    logic        op;
    logic [7:0]  entry_index;
    logic [31:0] energy;
    logic [31:0] cs_value;
    logic        first_point;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cs_out;
    logic [2:0]  region;
  } out_item_t;

  // query handed from front to back
  typedef struct packed {
    logic        below;
    logic        first_point;
    logic [31:0] energy;
  } query_t;

endpackage

### rtl/tli_ram.sv
// generic single write, single read ram with registered read
module tli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/tli_front.sv
// front end: accepts items, classifies queries, queues them for the back end
module tli_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  tli_pkg::in_item_t         item_i,
  input  logic [31:0]               threshold_i,
  input  logic                      elastic_i,
  input  logic                      back_idle_i,
  output logic                      load_we_o,
  output logic [tli_pkg::AddrW-1:0] load_addr_o,
  output logic                      q_valid_o,
  output tli_pkg::query_t           q_data_o,
  input  logic                      q_pop_i
);
  // two-entry queue
  tli_pkg::query_t fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic rd_q, wr_q;
  logic acc, push;
  tli_pkg::query_t cls;

  // a load waits until every earlier query has finished with the table
  assign busy_o = (cnt_q == 2'd2) ||
                  ((item_i.op == tli_pkg::OpLoad) && ((cnt_q != 2'd0) || !back_idle_i));
  assign acc = start_i && !busy_o;
  assign push = acc && (item_i.op == tli_pkg::OpQuery);
  assign load_we_o = acc && (item_i.op == tli_pkg::OpLoad);
  assign load_addr_o = item_i.entry_index[tli_pkg::AddrW-1:0];

  always_comb begin
    cls.below = !elastic_i && (item_i.energy <= threshold_i);
    cls.first_point = item_i.first_point;
    cls.energy = item_i.energy;
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = fifo_q[rd_q];
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cls;
  end
endmodule

### rtl/tli_back.sv
// back end: table walk, serial divide and result strobe
module tli_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tli_pkg::CountW-1:0] entry_count_i,
  input  logic                       q_valid_i,
  input  tli_pkg::query_t            q_data_i,
  output logic                       q_pop_o,
  output logic                       idle_o,
  output logic [tli_pkg::AddrW-1:0]  raddr_o,
  input  logic [31:0]                e_rd_i,
  input  logic [31:0]                c_rd_i,
  output logic                       res_valid_o,
  output tli_pkg::out_item_t         res_o
);
  typedef enum logic [3:0] {
    SIdle, SRead, SCmp, SLowRd, SLowWait, SMul, SDiv, SFin, SOut
  } state_e;

  state_e state_q;
  logic [tli_pkg::CountW-1:0] ptr_q, n_lim;
  logic [31:0] q_energy_q, e1_q, c1_q, e0_q, c0_q, span_q;
  logic [63:0] rem_q;
  logic [63:0] quo_q;
  logic [6:0] bit_q;
  logic down_q;
  tli_pkg::out_item_t res_q;
  logic [31:0] qc;
  logic [64:0] trial;

  assign n_lim = (entry_count_i > tli_pkg::CountW'(tli_pkg::TableDepth))
               ? tli_pkg::CountW'(tli_pkg::TableDepth) : entry_count_i;
  assign qc = (q_energy_q < e0_q) ? e0_q : ((q_energy_q > e1_q) ? e1_q : q_energy_q);
  assign q_pop_o = (state_q == SIdle) && q_valid_i;
  assign idle_o = (state_q == SIdle);
  assign res_o = res_q;
  assign res_valid_o = (state_q == SOut);
  // rem holds the shifting dividend high half, quo the low half then quotient
  assign trial = {rem_q, quo_q[63]} - {33'd0, span_q};

  always_comb begin
    raddr_o = ptr_q[tli_pkg::AddrW-1:0];
    if (state_q == SLowRd) raddr_o = tli_pkg::AddrW'(ptr_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ptr_q <= '0;
      q_energy_q <= '0; e1_q <= '0; c1_q <= '0; e0_q <= '0; c0_q <= '0;
      span_q <= '0; rem_q <= '0; quo_q <= '0; bit_q <= '0;
      down_q <= 1'b0; res_q <= '0;
    end else begin
      case (state_q)
        SIdle: if (q_valid_i) begin
          q_energy_q <= q_data_i.energy;
          if (q_data_i.first_point) ptr_q <= '0;
          if (q_data_i.below) begin
            res_q <= '{cs_out: 32'd0, region: tli_pkg::RegionBelow};
            state_q <= SOut;
          end else begin
            state_q <= SRead;
          end
        end
        SRead: begin
          if (ptr_q >= n_lim) begin
            res_q <= '{cs_out: 32'd0, region: tli_pkg::RegionBeyond};
            state_q <= SOut;
          end else begin
            state_q <= SCmp;
          end
        end
        SCmp: begin
          if (e_rd_i < q_energy_q) begin
            ptr_q <= ptr_q + 1'b1;
            state_q <= SRead;
          end else if (ptr_q == '0) begin
            if (e_rd_i == q_energy_q) begin
              res_q <= '{cs_out: c_rd_i, region: tli_pkg::RegionExact};
            end else begin
              res_q <= '{cs_out: 32'd0, region: tli_pkg::RegionBefore};
            end
            state_q <= SOut;
          end else begin
            e1_q <= e_rd_i;
            c1_q <= c_rd_i;
            state_q <= SLowRd;
          end
        end
        SLowRd: state_q <= SLowWait;
        SLowWait: begin
          e0_q <= e_rd_i;
          c0_q <= c_rd_i;
          state_q <= SMul;
        end
        SMul: begin
          if (e1_q <= e0_q) begin
            res_q <= '{cs_out: c1_q, region: tli_pkg::RegionInterp};
            state_q <= SOut;
          end else begin
            span_q <= e1_q - e0_q;
            down_q <= (c1_q < c0_q);
            quo_q <= (c1_q >= c0_q) ? 64'(c1_q - c0_q) * 64'(qc - e0_q)
                                   : 64'(c0_q - c1_q) * 64'(qc - e0_q);
            rem_q <= '0;
            bit_q <= 7'd64;
            state_q <= SDiv;
          end
        end
        SDiv: begin
          if (!trial[64]) begin
            rem_q <= trial[63:0];
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= {rem_q[62:0], quo_q[63]};
            quo_q <= {quo_q[62:0], 1'b0};
          end
          bit_q <= bit_q - 1'b1;
          if (bit_q == 7'd1) state_q <= SFin;
        end
        SFin: begin
          if (down_q) begin
            res_q <= '{cs_out: c0_q - (quo_q[31:0] + {31'd0, (rem_q != '0)}),
                       region: tli_pkg::RegionInterp};
          end else begin
            res_q <= '{cs_out: c0_q + quo_q[31:0], region: tli_pkg::RegionInterp};
          end
          state_q <= SOut;
        end
        SOut: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

### rtl/table_linear_interpolator.sv
// top level of the table linear interpolator
// Loads give no result; a load is held off by busy until
// every earlier query has left the block, so it never changes the table under
// a query still waiting. Once the back end takes a query that is not below the
// threshold it walks the table one entry at a time from the walk pointer, then
// for a pair of ascending entries a 64-step restoring divider computes the
// interpolation. Two queries can wait in the front queue; busy is high while it
// is full. Each result shows for one cycle on result_valid_o and cannot be
// stalled.
module table_linear_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  tli_pkg::in_item_t            item_i,
  output logic                         result_valid_o,
  output tli_pkg::out_item_t           result_o,
  input  logic                         cfg_we_i,
  input  logic [tli_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tli_pkg::CfgDataW-1:0] cfg_data_i
);
  logic [31:0] threshold_q;
  logic elastic_q;
  logic [tli_pkg::CountW-1:0] count_q;
  logic load_we, q_valid, q_pop, back_idle;
  logic [tli_pkg::AddrW-1:0] load_addr, raddr;
  tli_pkg::query_t q_data;
  logic [31:0] e_rd, c_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      elastic_q <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tli_pkg::CfgThreshold:   threshold_q <= cfg_data_i[31:0];
        tli_pkg::CfgElasticMode: elastic_q <= cfg_data_i[0];
        tli_pkg::CfgEntryCount:  count_q <= cfg_data_i[tli_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  tli_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .item_i,
    .threshold_i(threshold_q), .elastic_i(elastic_q), .back_idle_i(back_idle),
    .load_we_o(load_we), .load_addr_o(load_addr),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  tli_ram #(.Width(32), .Depth(tli_pkg::TableDepth)) u_energy (
    .clk_i, .we_i(load_we), .waddr_i(load_addr), .wdata_i(item_i.energy),
    .raddr_i(raddr), .rdata_o(e_rd)
  );

  tli_ram #(.Width(32), .Depth(tli_pkg::TableDepth)) u_cs (
    .clk_i, .we_i(load_we), .waddr_i(load_addr), .wdata_i(item_i.cs_value),
    .raddr_i(raddr), .rdata_o(c_rd)
  );

  tli_back u_back (
    .clk_i, .rst_ni, .entry_count_i(count_q),
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop), .idle_o(back_idle),
    .raddr_o(raddr), .e_rd_i(e_rd), .c_rd_i(c_rd),
    .res_valid_o(result_valid_o), .res_o(result_o)
  );
endmodule

### rtl/tli_checker.sv
// port-level checker for the table linear interpolator
module tli_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input tli_pkg::out_item_t result_o
);
  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.region <= tli_pkg::RegionBeyond))
    else $error("region out of range");
  a_zero_regions: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.region == tli_pkg::RegionBelow ||
      result_o.region == tli_pkg::RegionBefore ||
      result_o.region == tli_pkg::RegionBeyond) |-> (result_o.cs_out == 32'd0))
    else $error("nonzero result in zero region");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes back to back");
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !busy && !result_valid_o)
    else $error("activity during reset");
endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .result_o
);

### tb/tb.sv
// testbench for the table linear interpolator: random table loads and grid walks
`timescale 1ns / 1ps

module tb;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  tli_pkg::in_item_t            item_i = '0;
  logic                         result_valid_o;
  tli_pkg::out_item_t           result_o;
  logic                         cfg_we_i = 1'b0;
  logic [tli_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [tli_pkg::CfgDataW-1:0] cfg_data_i = '0;

  table_linear_interpolator DUT (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block state
  logic [31:0] energy_tab [tli_pkg::TableDepth];
  logic [31:0] cs_tab [tli_pkg::TableDepth];
  int unsigned walk_ptr;
  logic [31:0] thr_reg;
  logic        elastic_reg;
  logic [8:0]  count_reg;

  tli_pkg::in_item_t  pending_q[$];
  tli_pkg::out_item_t expected_cs_q[$];
  int        fail_cnt = 0;
  int        items_sent = 0;

  function automatic logic [31:0] lerp_cs(logic [31:0] e0, logic [31:0] e1,
                                          logic [31:0] c0, logic [31:0] c1,
                                          logic [31:0] q);
    logic [63:0] span, offs, prod, quot;
    if (e1 <= e0) return c1;
    if (q < e0) q = e0;
    if (q > e1) q = e1;
    span = 64'(e1) - 64'(e0);
    offs = 64'(q) - 64'(e0);
    if (c1 >= c0) begin
      prod = (64'(c1) - 64'(c0)) * offs;
      return 32'(64'(c0) + prod / span);
    end
    prod = (64'(c0) - 64'(c1)) * offs;
    quot = prod / span;
    if (prod % span != 0) quot++;
    return 32'(64'(c0) - quot);
  endfunction

  // applies one accepted beat to the shadow state
  function automatic void predict_cross_section(tli_pkg::in_item_t it);
    tli_pkg::out_item_t r;
    int unsigned n, p;
    if (it.op == tli_pkg::OpLoad) begin
      energy_tab[it.entry_index] = it.energy;
      cs_tab[it.entry_index] = it.cs_value;
      return;
    end
    if (it.first_point) walk_ptr = 0;
    if (!elastic_reg && it.energy <= thr_reg) begin
      r.cs_out = '0;
      r.region = tli_pkg::RegionBelow;
    end else begin
      n = (count_reg > tli_pkg::TableDepth) ? tli_pkg::TableDepth : count_reg;
      p = walk_ptr;
      while (p < n && energy_tab[p] < it.energy) p++;
      walk_ptr = p;
      if (p >= n) begin
        r.cs_out = '0;
        r.region = tli_pkg::RegionBeyond;
      end else if (p == 0) begin
        if (energy_tab[0] == it.energy) begin
          r.cs_out = cs_tab[0];
          r.region = tli_pkg::RegionExact;
        end else begin
          r.cs_out = '0;
          r.region = tli_pkg::RegionBefore;
        end
      end else begin
        r.cs_out = lerp_cs(energy_tab[p-1], energy_tab[p], cs_tab[p-1], cs_tab[p],
                           it.energy);
        r.region = tli_pkg::RegionInterp;
      end
    end
    expected_cs_q.push_back(r);
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      walk_ptr = 0;
    end else begin
      if (start && !busy) begin
        predict_cross_section(item_i);
        void'(pending_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      nxt = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pending_q.size() > 0) nxt = 1'b1;
      start <= nxt;
      if (nxt) item_i <= pending_q[0];
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tli_pkg::out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_cs_q.size() == 0) begin
        $error("result beat with nothing expected: cs_out %h region %0d",
               result_o.cs_out, result_o.region);
        fail_cnt++;
      end else begin
        want = expected_cs_q.pop_front();
        if (result_o.cs_out !== want.cs_out) begin
          $error("cs_out expected %h actual %h", want.cs_out, result_o.cs_out);
          fail_cnt++;
        end
        if (result_o.region !== want.region) begin
          $error("region expected %0d actual %0d", want.region, result_o.region);
          fail_cnt++;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || expected_cs_q.size() != 0) @(posedge clk_i);
    // loads give no result, and a long walk may still be running
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [tli_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == tli_pkg::CfgThreshold) thr_reg = val;
    else if (idx == tli_pkg::CfgElasticMode) elastic_reg = val[0];
    else if (idx == tli_pkg::CfgEntryCount) count_reg = val[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void push_load(int idx, logic [31:0] e, logic [31:0] c);
    tli_pkg::in_item_t it;
    it = '0;
    it.op = tli_pkg::OpLoad;
    it.entry_index = idx[7:0];
    it.energy = e;
    it.cs_value = c;
    it.first_point = 1'($urandom_range(0, 1));
    pending_q.push_back(it);
    items_sent++;
  endfunction

  function automatic void push_query(logic [31:0] e, logic first);
    tli_pkg::in_item_t it;
    it.op = tli_pkg::OpQuery;
    it.entry_index = 8'($urandom);
    it.energy = e;
    it.cs_value = $urandom;
    it.first_point = first;
    pending_q.push_back(it);
    items_sent++;
  endfunction

  initial begin
    logic [31:0] tab_e [tli_pkg::TableDepth];
    logic [31:0] base, q, lo, hi;
    int          n, nq, phase;
    thr_reg = '0;
    elastic_reg = 1'b0;
    count_reg = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: threshold, before/exact, clamp, beyond
    write_cfg(tli_pkg::CfgThreshold, 32'h100);
    write_cfg(tli_pkg::CfgElasticMode, 32'd0);
    write_cfg(tli_pkg::CfgEntryCount, 32'd4);
    push_load(0, 32'h200, 32'd100);
    push_load(1, 32'h400, 32'd50);
    push_load(2, 32'h400, 32'd7);
    push_load(3, 32'h800, 32'hFFFF_FFFF);
    push_load(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_query(32'h0, 1'b1);
    push_query(32'h100, 1'b0);
    push_query(32'h150, 1'b1);
    push_query(32'h200, 1'b1);
    push_query(32'h333, 1'b0);
    push_query(32'h400, 1'b0);
    push_query(32'h555, 1'b0);
    push_query(32'h300, 1'b0);
    push_query(32'h900, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b0);
    wait_idle();
    // every point at or below the threshold
    write_cfg(tli_pkg::CfgThreshold, 32'hFFFF_FFFF);
    push_query(32'h0, 1'b1);
    push_query(32'h800, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b0);
    wait_idle();
    // elastic mode with an empty table
    write_cfg(tli_pkg::CfgElasticMode, 32'd1);
    write_cfg(tli_pkg::CfgEntryCount, 32'd0);
    push_query(32'h0, 1'b1);
    push_query(32'h1234, 1'b0);
    wait_idle();

    phase = 0;
    while (items_sent < 650) begin
      case (phase)
        0: n = 256;
        1: n = 256;
        default: n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
      endcase
      // table energies, mostly ascending
      base = $urandom_range(0, 32'h0FFF_FFFF);
      for (int i = 0; i < n; i++) begin
        tab_e[i] = base;
        if ($urandom_range(0, 15) == 0) base = base;
        else if ($urandom_range(0, 31) == 0) base = base - $urandom_range(1, 1000);
        else base = base + $urandom_range(1, 1 << 18);
      end
      if (phase != 1) begin
        for (int i = 0; i < n; i++) push_load(i, tab_e[i], $urandom);
      end
      wait_idle();
      write_cfg(tli_pkg::CfgThreshold, ($urandom_range(0, 3) == 0) ? 32'd0 :
                tab_e[0] + $urandom_range(0, 1 << 20) - 32'h8_0000);
      write_cfg(tli_pkg::CfgElasticMode, $urandom_range(0, 1));
      write_cfg(tli_pkg::CfgEntryCount, (phase == 1) ? 32'd511 : n);
      lo = (n > 0) ? tab_e[0] - $urandom_range(0, 1 << 16) : $urandom;
      hi = (n > 0) ? tab_e[n-1] + $urandom_range(0, 1 << 16) : lo + 32'h10_0000;
      nq = $urandom_range(20, 60);
      for (int s = 0; s < nq; s += 8) begin
        // ascending sweep with a rewind, then a little noise
        q = lo;
        push_query(q, 1'b1);
        for (int k = 0; k < 7; k++) begin
          if ($urandom_range(0, 9) == 0) push_query($urandom, 1'($urandom_range(0, 1)));
          else begin
            q = q + ((hi - lo) >> 3) + $urandom_range(0, 1 << 12);
            if ($urandom_range(0, 7) == 0 && n > 0) q = tab_e[8'($urandom_range(0, n - 1))];
            push_query(q, 1'b0);
          end
        end
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (fail_cnt == 0 && expected_cs_q.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
